@@ design/acdn_pkg.sv @@
// Shared types, codes and depth helpers for the alpha composite depth normalise unit.
`default_nettype none

package acdn_pkg;

	// Number of pipeline cells from input word to output word
	localparam int unsigned STAGES = 6;

	// Sample depth codes
	localparam logic [1:0] DEPTH_8  = 2'd0;
	localparam logic [1:0] DEPTH_10 = 2'd1;
	localparam logic [1:0] DEPTH_12 = 2'd2;
	localparam logic [1:0] DEPTH_16 = 2'd3;

	// Configuration register indexes
	localparam logic [1:0] CFG_SAMPLE_DEPTH  = 2'd0;
	localparam logic [1:0] CFG_ALPHA_PRESENT = 2'd1;
	localparam logic [1:0] CFG_BACKGROUND    = 2'd2;

	// Rounding bias for the byte scale, and reciprocal of 255 (exact below 2^24)
	localparam logic [23:0] BYTE_HALF      = 24'd127;
	localparam logic [23:0] BG_RECIP       = 24'd8421505;
	localparam int unsigned BG_RECIP_SHIFT = 31;

	typedef struct packed {
		logic [15:0] red_in;
		logic [15:0] green_in;
		logic [15:0] blue_in;
		logic [15:0] alpha_in;
	} pixel_in_t;

	typedef struct packed {
		logic [15:0] red_out;
		logic [15:0] green_out;
		logic [15:0] blue_out;
	} pixel_out_t;

	// Handshake state of one pipeline cell
	typedef struct packed {
		logic valid;
		logic ready;
		logic load;
	} stage_ctl_t;

	// Largest sample value at a depth
	function automatic logic [15:0] depth_top(input logic [1:0] code);
		logic [15:0] top;
		case (code)
			DEPTH_8:  top = 16'h00FF;
			DEPTH_10: top = 16'h03FF;
			DEPTH_12: top = 16'h0FFF;
			DEPTH_16: top = 16'hFFFF;
			default:  top = 16'h00FF;
		endcase
		return top;
	endfunction

	// Number of bits at a depth
	function automatic logic [4:0] depth_shift(input logic [1:0] code);
		logic [4:0] sh;
		case (code)
			DEPTH_8:  sh = 5'd8;
			DEPTH_10: sh = 5'd10;
			DEPTH_12: sh = 5'd12;
			DEPTH_16: sh = 5'd16;
			default:  sh = 5'd8;
		endcase
		return sh;
	endfunction

endpackage

`default_nettype wire

@@ design/acdn_cell.sv @@
// One pipeline cell: holds the valid bit of its stage and hands the word onward.
`default_nettype none

module acdn_cell (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   up_valid,
	input  wire logic                   dn_ready,
	output acdn_pkg::stage_ctl_t        ctl
);

	logic valid_q;
	logic take;

	// Advance when empty or when the next cell takes the word
	assign take = !valid_q || dn_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (take) begin
			valid_q <= up_valid;
		end
	end

	assign ctl.valid = valid_q;
	assign ctl.ready = take;
	assign ctl.load  = take && up_valid;

endmodule

`default_nettype wire

@@ design/acdn_lane.sv @@
// Datapath of one colour through the cell chain: clamp, blend, divide, rescale.
`default_nettype none

module acdn_lane (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic [acdn_pkg::STAGES-1:0]   load,
	input  wire logic [1:0]                    depth,
	input  wire logic [7:0]                    bg8,
	input  wire logic [15:0]                   sample,
	input  wire logic [15:0]                   alpha_s1,
	input  wire logic [15:0]                   alpha_inv_s1,
	output logic [15:0]                        result
);

	logic [15:0] top;
	logic [4:0]  sh;
	logic [15:0] half;

	logic [23:0] bg_prod;
	logic [23:0] bgp_q;
	logic [47:0] bg_full;
	logic [15:0] bgs_q;

	logic [15:0] s_clamp;
	logic [15:0] s_s1;
	logic [31:0] p_sa_s2;
	logic [31:0] p_bg_s2;
	logic [32:0] n_sum;
	logic [31:0] n_s3;
	logic [32:0] n_ext;
	logic [32:0] n_rnd;
	logic [32:0] n_quo;
	logic [15:0] v_s4;
	logic [31:0] x_full;
	logic [31:0] x_hi;
	logic [15:0] xh_s5;
	logic [15:0] xl_s5;
	logic [15:0] v_s5;
	logic [17:0] y_ext;
	logic [17:0] y_rnd;
	logic [17:0] y_quo;
	logic [15:0] rescaled;
	logic [15:0] res_s6;

	assign top  = acdn_pkg::depth_top(depth);
	assign sh   = acdn_pkg::depth_shift(depth);
	assign half = top >> 1;

	// Scale the byte background to depth: (bg*max + 127) / 255
	assign bg_prod = {8'd0, top} * {16'd0, bg8};
	assign bg_full = {24'd0, bgp_q} * {24'd0, acdn_pkg::BG_RECIP};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bgp_q <= acdn_pkg::BYTE_HALF;
			bgs_q <= 16'd0;
		end else begin
			bgp_q <= bg_prod + acdn_pkg::BYTE_HALF;
			bgs_q <= bg_full[acdn_pkg::BG_RECIP_SHIFT +: 16];
		end
	end

	// Stage 1: clamp the sample to max
	assign s_clamp = (sample > top) ? top : sample;

	always_ff @(posedge clk) begin
		if (load[0]) begin
			s_s1 <= s_clamp;
		end
	end

	// Stage 2: foreground and background products
	always_ff @(posedge clk) begin
		if (load[1]) begin
			p_sa_s2 <= {16'd0, s_s1} * {16'd0, alpha_s1};
			p_bg_s2 <= {16'd0, bgs_q} * {16'd0, alpha_inv_s1};
		end
	end

	// Stage 3: sum with half of max for rounding
	assign n_sum = {1'b0, p_sa_s2} + {1'b0, p_bg_s2} + {17'd0, half};

	always_ff @(posedge clk) begin
		if (load[2]) begin
			n_s3 <= n_sum[31:0];
		end
	end

	// Stage 4: divide by 2^n-1 as (x + (x >> n) + 1) >> n
	assign n_ext = {1'b0, n_s3};
	assign n_rnd = n_ext + (n_ext >> sh) + 33'd1;
	assign n_quo = n_rnd >> sh;

	always_ff @(posedge clk) begin
		if (load[3]) begin
			v_s4 <= n_quo[15:0];
		end
	end

	// Stage 5: form v*65535 + max/2 and split it at bit n
	assign x_full = {v_s4, 16'd0} - {16'd0, v_s4} + {16'd0, half};
	assign x_hi   = x_full >> sh;

	always_ff @(posedge clk) begin
		if (load[4]) begin
			xh_s5 <= x_hi[15:0];
			xl_s5 <= x_full[15:0] & top;
			v_s5  <= v_s4;
		end
	end

	// Stage 6: x / (2^n-1) = hi + (hi + lo) / (2^n-1)
	assign y_ext    = {2'd0, xh_s5} + {2'd0, xl_s5};
	assign y_rnd    = y_ext + (y_ext >> sh) + 18'd1;
	assign y_quo    = y_rnd >> sh;
	assign rescaled = xh_s5 + y_quo[15:0];

	always_ff @(posedge clk) begin
		if (load[5]) begin
			if (depth inside {acdn_pkg::DEPTH_10, acdn_pkg::DEPTH_12}) begin
				res_s6 <= rescaled;
			end else begin
				res_s6 <= v_s5;
			end
		end
	end

	assign result = res_s6;

endmodule

`default_nettype wire

@@ design/alpha_composite_depth_normalize_unit.sv @@
// Throughput: one word per cycle while the output is taken, through a chain of 6 cells, each of which
// takes a new word whenever it is empty or its neighbour takes its word.
// A background write passes through bg_q, bgp_q and bgs_q before the scaled background is used.
// Reset clears the configuration registers and all cell valid bits.
`default_nettype none

module alpha_composite_depth_normalize_unit (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire acdn_pkg::pixel_in_t  in_data,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output acdn_pkg::pixel_out_t      out_data,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [1:0]           cfg_index,
	input  wire logic [23:0]          cfg_data
);

	localparam int unsigned LAST = acdn_pkg::STAGES - 1;

	logic [1:0]  depth_q;
	logic        alpha_en_q;
	logic [23:0] bg_q;

	acdn_pkg::stage_ctl_t            ctl [acdn_pkg::STAGES];
	logic [acdn_pkg::STAGES-1:0]     load;
	logic [acdn_pkg::STAGES-1:0]     valid;

	logic [15:0] top;
	logic [15:0] alpha_clamp;
	logic [15:0] alpha_eff;
	logic [15:0] alpha_s1;
	logic [15:0] alpha_inv_s1;
	logic [15:0] red_res;
	logic [15:0] green_res;
	logic [15:0] blue_res;

	// Take configuration writes; unknown indexes are dropped
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q    <= acdn_pkg::DEPTH_8;
			alpha_en_q <= 1'b0;
			bg_q       <= 24'd0;
		end else if (cfg_valid) begin
			case (cfg_index)
				acdn_pkg::CFG_SAMPLE_DEPTH:  depth_q    <= cfg_data[1:0];
				acdn_pkg::CFG_ALPHA_PRESENT: alpha_en_q <= cfg_data[0];
				acdn_pkg::CFG_BACKGROUND:    bg_q       <= cfg_data;
				default: ;
			endcase
		end
	end

	// Chain of cells: each passes its word to the next when it is taken
	genvar k;
	generate
		for (k = 0; k < acdn_pkg::STAGES; k++) begin : g_cell
			logic up_v;
			logic dn_r;
			if (k == 0) begin : g_first
				assign up_v = in_valid;
			end else begin : g_mid
				assign up_v = ctl[k-1].valid;
			end
			if (k == LAST) begin : g_last
				assign dn_r = out_ready;
			end else begin : g_inner
				assign dn_r = ctl[k+1].ready;
			end
			acdn_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.up_valid (up_v),
				.dn_ready (dn_r),
				.ctl      (ctl[k])
			);
			assign load[k]  = ctl[k].load;
			assign valid[k] = ctl[k].valid;
		end
	endgenerate

	assign in_ready  = ctl[0].ready;
	assign out_valid = ctl[LAST].valid;

	// Clamp alpha, or force it opaque when the alpha-present setting is off
	assign top         = acdn_pkg::depth_top(depth_q);
	assign alpha_clamp = (in_data.alpha_in > top) ? top : in_data.alpha_in;
	assign alpha_eff   = alpha_en_q ? alpha_clamp : top;

	always_ff @(posedge clk) begin
		if (load[0]) begin
			alpha_s1     <= alpha_eff;
			alpha_inv_s1 <= top - alpha_eff;
		end
	end

	// One lane per colour
	acdn_lane u_red (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (load),
		.depth        (depth_q),
		.bg8          (bg_q[23:16]),
		.sample       (in_data.red_in),
		.alpha_s1     (alpha_s1),
		.alpha_inv_s1 (alpha_inv_s1),
		.result       (red_res)
	);

	acdn_lane u_green (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (load),
		.depth        (depth_q),
		.bg8          (bg_q[15:8]),
		.sample       (in_data.green_in),
		.alpha_s1     (alpha_s1),
		.alpha_inv_s1 (alpha_inv_s1),
		.result       (green_res)
	);

	acdn_lane u_blue (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (load),
		.depth        (depth_q),
		.bg8          (bg_q[7:0]),
		.sample       (in_data.blue_in),
		.alpha_s1     (alpha_s1),
		.alpha_inv_s1 (alpha_inv_s1),
		.result       (blue_res)
	);

	assign out_data.red_out   = red_res;
	assign out_data.green_out = green_res;
	assign out_data.blue_out  = blue_res;

	// Input stalls only when every cell holds a word
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (&valid))
		else $error("input stalled with an empty cell");

	// An accepted word lands in the first cell
	a_accept_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> valid[0])
		else $error("accepted word lost at first cell");

	// A word held back by the output cell is not dropped
	a_hold_word: assert property (@(posedge clk) disable iff (!arst_n)
		(valid[LAST-1] && !ctl[LAST].ready) |=> valid[LAST-1])
		else $error("word dropped while output cell stalled");

	// At depth 8 the results stay within a byte
	a_byte_range: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && depth_q == acdn_pkg::DEPTH_8) |->
			(out_data.red_out[15:8] == 8'd0 && out_data.green_out[15:8] == 8'd0 &&
			 out_data.blue_out[15:8] == 8'd0))
		else $error("8-bit result out of range");

endmodule

`default_nettype wire
